// ===== rtl/rspc_pkg.sv =====
// Types, constants and the angle saturation function of the remote servo position controller.
package rspc_pkg;

    localparam int unsigned MAC_W     = 48;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned GAIN_W    = 6;
    localparam int unsigned ANGLE_W   = 8;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned DELTA_W   = 16;
    localparam int unsigned BTN_W     = 8;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 48;
    localparam int unsigned SUM_W     = 40;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_FILTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ANGLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE     = 3'd5;

    localparam logic [LEN_W-1:0]     PACKET_LEN     = 8'd16;
    localparam logic [ANGLE_W-1:0]   ANGLE_LIMIT    = 8'd180;
    localparam logic [ANGLE_W-1:0]   PRESET_0       = 8'd0;
    localparam logic [ANGLE_W-1:0]   PRESET_1       = 8'd45;
    localparam logic [ANGLE_W-1:0]   PRESET_2       = 8'd90;
    localparam logic [ANGLE_W-1:0]   PRESET_3       = 8'd135;
    localparam logic [ANGLE_W-1:0]   PRESET_4       = 8'd180;
    localparam int unsigned          CENTER_BIT     = 5;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = 17'h1FFFF;

    localparam logic [MAC_W-1:0]     RST_SENDER     = '0;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 16'd1500;
    localparam logic [GAIN_W-1:0]    RST_GAIN       = 6'd4;
    localparam logic [ANGLE_W-1:0]   RST_CENTER     = 8'd90;
    localparam logic [ANGLE_W-1:0]   RST_MIN        = 8'd0;
    localparam logic [ANGLE_W-1:0]   RST_MAX        = 8'd180;
    localparam logic [ANGLE_W-1:0]   RST_ANGLE      = 8'd90;

    typedef struct packed {
        logic [MAC_W-1:0]     sender_filter;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [GAIN_W-1:0]    step_gain;
        logic [ANGLE_W-1:0]   center_angle;
        logic [ANGLE_W-1:0]   min_angle;
        logic [ANGLE_W-1:0]   max_angle;
    } cfg_t;

    typedef struct packed {
        logic                      cmd;
        logic [MAC_W-1:0]          src_mac;
        logic [LEN_W-1:0]          packet_length;
        logic signed [POS_W-1:0]   encoder_position;
        logic signed [DELTA_W-1:0] encoder_delta;
        logic [BTN_W-1:0]          buttons;
        logic                      encoder_pressed;
    } item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               packet_accepted;
        logic               timed_out;
        logic               link_alive;
    } result_t;

    // Clamp to the lower limit, then the upper limit, then the mechanical limit, then to zero from below.
    function automatic logic [ANGLE_W-1:0] sat_angle(
        input logic signed [SUM_W-1:0] x,
        input logic [ANGLE_W-1:0]      lo,
        input logic [ANGLE_W-1:0]      hi
    );
        logic signed [SUM_W-1:0] v;
        v = x;
        if (v < $signed({{(SUM_W-ANGLE_W){1'b0}}, lo}))
            v = $signed({{(SUM_W-ANGLE_W){1'b0}}, lo});
        if (v > $signed({{(SUM_W-ANGLE_W){1'b0}}, hi}))
            v = $signed({{(SUM_W-ANGLE_W){1'b0}}, hi});
        if (v > $signed({{(SUM_W-ANGLE_W){1'b0}}, ANGLE_LIMIT}))
            v = $signed({{(SUM_W-ANGLE_W){1'b0}}, ANGLE_LIMIT});
        if (v < 0)
            v = '0;
        return v[ANGLE_W-1:0];
    endfunction

endpackage

// ===== rtl/remote_servo_position_controller_unit.sv =====
// Top level of the remote servo position controller: input register, core and result register.
// Unless stalled, the block takes one item per clock, a received packet or a millisecond tick, and returns one
// result item for each. An accepted item lands in the input register; the core updates the servo
// state from it combinationally, and the servo state and the result register are written together
// once the result register is not held by a stalled output, which then presents the result.
// Throughput is one item per cycle while the output is not stalled, set by the combinational
// update of the angle, encoder history and link timer; in_stall rises only when the result
// register is full and stalled. Configuration writes are always taken (cfg_ready is high) and
// should be made while no item is in flight.
module remote_servo_position_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [rspc_pkg::MAC_W-1:0]          src_mac,
    input  logic [rspc_pkg::LEN_W-1:0]          packet_length,
    input  logic signed [rspc_pkg::POS_W-1:0]   encoder_position,
    input  logic signed [rspc_pkg::DELTA_W-1:0] encoder_delta,
    input  logic [rspc_pkg::BTN_W-1:0]          buttons,
    input  logic                                encoder_pressed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rspc_pkg::ANGLE_W-1:0]        angle,
    output logic                                packet_accepted,
    output logic                                timed_out,
    output logic                                link_alive,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rspc_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import rspc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_busy;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && out_stall;
    assign advance   = item_valid_reg && !out_busy;
    assign in_stall  = item_valid_reg && out_busy;
    assign in_take   = in_valid && !in_stall;

    rspc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rspc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd              <= cmd;
            item_reg.src_mac          <= src_mac;
            item_reg.packet_length    <= packet_length;
            item_reg.encoder_position <= encoder_position;
            item_reg.encoder_delta    <= encoder_delta;
            item_reg.buttons          <= buttons;
            item_reg.encoder_pressed  <= encoder_pressed;
        end
        if (advance)
            result_reg <= core_result;
    end

    assign out_valid       = out_valid_reg;
    assign angle           = result_reg.angle;
    assign packet_accepted = result_reg.packet_accepted;
    assign timed_out       = result_reg.timed_out;
    assign link_alive      = result_reg.link_alive;

    // A timeout fires only on ticks, so it never coincides with an accepted packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timed_out && packet_accepted))
        else $error("timeout and packet acceptance in the same item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle <= ANGLE_LIMIT))
        else $error("servo angle beyond mechanical limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> !link_alive)
        else $error("link still alive after timeout");

    // The input side stalls only while a full result register is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && item_valid_reg))
        else $error("input stalled without a held result");

endmodule

// ===== rtl/rspc_cfg.sv =====
// Configuration register file of the remote servo position controller.
module rspc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [rspc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [rspc_pkg::CFG_DAT_W-1:0] wr_data,
    output rspc_pkg::cfg_t                cfg
);
    import rspc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sender_filter <= RST_SENDER;
            cfg_reg.timeout_ms    <= RST_TIMEOUT;
            cfg_reg.step_gain     <= RST_GAIN;
            cfg_reg.center_angle  <= RST_CENTER;
            cfg_reg.min_angle     <= RST_MIN;
            cfg_reg.max_angle     <= RST_MAX;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_SENDER_FILTER: cfg_reg.sender_filter <= wr_data[MAC_W-1:0];
                CFG_TIMEOUT_MS:    cfg_reg.timeout_ms    <= wr_data[TIMEOUT_W-1:0];
                CFG_STEP_GAIN:     cfg_reg.step_gain     <= wr_data[GAIN_W-1:0];
                CFG_CENTER_ANGLE:  cfg_reg.center_angle  <= wr_data[ANGLE_W-1:0];
                CFG_MIN_ANGLE:     cfg_reg.min_angle     <= wr_data[ANGLE_W-1:0];
                CFG_MAX_ANGLE:     cfg_reg.max_angle     <= wr_data[ANGLE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rspc_core.sv =====
// Servo state and the combinational update for one packet or tick item.
module rspc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rspc_pkg::item_t   item,
    input  rspc_pkg::cfg_t    cfg,
    output rspc_pkg::result_t result
);
    import rspc_pkg::*;

    logic [ANGLE_W-1:0]   angle_reg,     angle_next;
    logic                 have_pos_reg,  have_pos_next;
    logic [POS_W-1:0]     last_pos_reg,  last_pos_next;
    logic                 link_up_reg,   link_up_next;
    logic [ELAPSED_W-1:0] elapsed_reg,   elapsed_next;

    logic                     pkt_ok;
    logic signed [POS_W-1:0]  move;
    logic signed [SUM_W-1:0]  product;
    logic signed [SUM_W-1:0]  sum;
    logic [ANGLE_W-1:0]       preset;
    logic [ANGLE_W-1:0]       center_sat;
    logic [ELAPSED_W-1:0]     elapsed_inc;
    logic                     fired;

    assign pkt_ok = (item.cmd == CMD_PACKET) && (item.packet_length == PACKET_LEN)
                    && ((cfg.sender_filter == '0) || (item.src_mac == cfg.sender_filter));

    // Position difference wraps in 32 bits; the first packet uses the reported delta.
    assign move = have_pos_reg
                  ? $signed(item.encoder_position - $signed(last_pos_reg))
                  : $signed({{(POS_W-DELTA_W){item.encoder_delta[DELTA_W-1]}},
                             item.encoder_delta});

    assign product = SUM_W'(move * $signed({1'b0, cfg.step_gain}));
    assign sum     = product + $signed({{(SUM_W-ANGLE_W){1'b0}}, angle_reg});

    assign center_sat = sat_angle($signed({{(SUM_W-ANGLE_W){1'b0}}, cfg.center_angle}),
                                  cfg.min_angle, cfg.max_angle);

    always_comb
    begin
        priority if (item.buttons[0]) preset = PRESET_0;
        else if (item.buttons[1])     preset = PRESET_1;
        else if (item.buttons[2])     preset = PRESET_2;
        else if (item.buttons[3])     preset = PRESET_3;
        else                          preset = PRESET_4;
    end

    assign elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;

    always_comb
    begin
        angle_next    = angle_reg;
        have_pos_next = have_pos_reg;
        last_pos_next = last_pos_reg;
        link_up_next  = link_up_reg;
        elapsed_next  = elapsed_reg;
        fired         = 1'b0;
        if (pkt_ok)
        begin
            link_up_next  = 1'b1;
            elapsed_next  = '0;
            have_pos_next = 1'b1;
            last_pos_next = item.encoder_position;
            priority if (item.encoder_pressed || item.buttons[CENTER_BIT])
                angle_next = center_sat;
            else if (item.buttons[4:0] != '0)
                angle_next = sat_angle($signed({{(SUM_W-ANGLE_W){1'b0}}, preset}),
                                       cfg.min_angle, cfg.max_angle);
            else if (move != '0)
                angle_next = sat_angle(sum, cfg.min_angle, cfg.max_angle);
        end
        else if ((item.cmd == CMD_TICK) && link_up_reg)
        begin
            if (elapsed_inc > {1'b0, cfg.timeout_ms})
            begin
                link_up_next = 1'b0;
                elapsed_next = '0;
                angle_next   = center_sat;
                fired        = 1'b1;
            end
            else
            begin
                elapsed_next = elapsed_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= RST_ANGLE;
            have_pos_reg <= 1'b0;
            last_pos_reg <= '0;
            link_up_reg  <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (step)
        begin
            angle_reg    <= angle_next;
            have_pos_reg <= have_pos_next;
            last_pos_reg <= last_pos_next;
            link_up_reg  <= link_up_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    assign result.angle           = angle_next;
    assign result.packet_accepted = pkt_ok;
    assign result.timed_out       = fired;
    assign result.link_alive      = link_up_next;

endmodule

// ===== sim/remote_servo_position_controller_unit_tb.sv =====
// Self-checking testbench for the remote servo position controller: directed rows, then random phases.
module remote_servo_position_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rspc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned ITEMS_PER_PHASE = 150;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned HEAVY_PCT       = 71;
    localparam int unsigned LIGHT_PCT       = 17;
    localparam int unsigned BURST_CAP       = 320;
    localparam logic [MAC_W-1:0] MAC_ONES   = '1;

    typedef enum int unsigned { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_value;
        item_t                it;
        bit                   typed;
        result_t              want;
    } row_t;

    logic                        clk              = 1'b0;
    logic                        rst_n            = 1'b0;
    logic                        in_valid         = 1'b0;
    logic                        in_stall;
    logic                        cmd              = CMD_PACKET;
    logic [MAC_W-1:0]            src_mac          = '0;
    logic [LEN_W-1:0]            packet_length    = '0;
    logic signed [POS_W-1:0]     encoder_position = '0;
    logic signed [DELTA_W-1:0]   encoder_delta    = '0;
    logic [BTN_W-1:0]            buttons          = '0;
    logic                        encoder_pressed  = 1'b0;
    logic                        out_valid;
    logic                        out_stall        = 1'b0;
    logic [ANGLE_W-1:0]          angle;
    logic                        packet_accepted;
    logic                        timed_out;
    logic                        link_alive;
    logic                        cfg_valid        = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index        = '0;
    logic [CFG_DAT_W-1:0]        cfg_data         = '0;

    // Servo model: register copies and state, at their reset values.
    logic [MAC_W-1:0]     flt_mac      = RST_SENDER;
    logic [TIMEOUT_W-1:0] link_timeout = RST_TIMEOUT;
    logic [GAIN_W-1:0]    gain         = RST_GAIN;
    logic [ANGLE_W-1:0]   home_angle   = RST_CENTER;
    logic [ANGLE_W-1:0]   lower_limit  = RST_MIN;
    logic [ANGLE_W-1:0]   upper_limit  = RST_MAX;
    logic [ANGLE_W-1:0]   servo_deg    = RST_ANGLE;
    logic                 pos_known    = 1'b0;
    logic [POS_W-1:0]     prev_pos     = '0;
    logic                 link_live    = 1'b0;
    logic [ELAPSED_W-1:0] quiet_ms     = '0;

    result_t     pending_results[$];
    result_t     oldest;
    row_t        directed_rows[$];
    cfg_t        phase_cfg[NUM_PHASES];
    int unsigned sender_gap_pct     = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatches         = 0;
    int unsigned live_items         = 0;
    int unsigned items_sent         = 0;
    int unsigned packets_taken      = 0;
    int unsigned timeouts_seen      = 0;
    int unsigned cycle_count        = 0;

    function automatic logic [ANGLE_W-1:0] limit_angle(longint x);
        longint lo, hi, top;
        lo  = lower_limit;
        hi  = upper_limit;
        top = ANGLE_LIMIT;
        if (x < lo)
            x = lo;
        if (x > hi)
            x = hi;
        if (x > top)
            x = top;
        if (x < 0)
            x = 0;
        return ANGLE_W'(x);
    endfunction

    function automatic result_t advance_servo(item_t it);
        result_t                   res;
        longint                    move, cur, g;
        logic signed [POS_W-1:0]   diff;
        logic signed [DELTA_W-1:0] first_step;
        res = '0;
        if (it.cmd == CMD_PACKET)
        begin
            if (it.packet_length == PACKET_LEN && (flt_mac == '0 || it.src_mac == flt_mac))
            begin
                res.packet_accepted = 1'b1;
                link_live = 1'b1;
                quiet_ms = '0;
                diff = it.encoder_position - prev_pos;
                first_step = it.encoder_delta;
                if (pos_known)
                    move = diff;
                else
                    move = first_step;
                prev_pos = it.encoder_position;
                pos_known = 1'b1;
                cur = servo_deg;
                g = gain;
                if (move != 0)
                    servo_deg = limit_angle(cur + move * g);
                if (it.buttons[0])
                    servo_deg = limit_angle(PRESET_0);
                else if (it.buttons[1])
                    servo_deg = limit_angle(PRESET_1);
                else if (it.buttons[2])
                    servo_deg = limit_angle(PRESET_2);
                else if (it.buttons[3])
                    servo_deg = limit_angle(PRESET_3);
                else if (it.buttons[4])
                    servo_deg = limit_angle(PRESET_4);
                if (it.buttons[CENTER_BIT] || it.encoder_pressed)
                    servo_deg = limit_angle(home_angle);
            end
        end
        else if (link_live)
        begin
            if (quiet_ms != ELAPSED_MAX)
                quiet_ms = quiet_ms + 1'b1;
            if (quiet_ms > link_timeout)
            begin
                link_live = 1'b0;
                quiet_ms = '0;
                servo_deg = limit_angle(home_angle);
                res.timed_out = 1'b1;
            end
        end
        res.angle = servo_deg;
        res.link_alive = link_live;
        return res;
    endfunction

    // Ticks, or mostly well-formed packets that track the last position, with some noise mixed in.
    function automatic item_t make_item(bit tick);
        item_t       it;
        int unsigned pick;
        it.cmd = tick ? CMD_TICK : CMD_PACKET;
        it.src_mac = MAC_W'({$urandom, $urandom});
        it.packet_length = LEN_W'($urandom);
        it.encoder_position = $urandom;
        it.encoder_delta = DELTA_W'($urandom);
        it.buttons = BTN_W'($urandom);
        it.encoder_pressed = 1'($urandom_range(1));
        if (!tick && $urandom_range(99) < 85)
        begin
            it.packet_length = PACKET_LEN;
            if (flt_mac != '0 && $urandom_range(9) != 0)
                it.src_mac = flt_mac;
            pick = $urandom_range(9);
            if (pick < 7)
                it.encoder_position = prev_pos + POS_W'($urandom_range(20)) - POS_W'(10);
            else if (pick == 7)
                it.encoder_position = prev_pos;
            it.buttons = ($urandom_range(7) == 0) ? BTN_W'($urandom) : '0;
            it.encoder_pressed = ($urandom_range(24) == 0);
        end
        return it;
    endfunction

    function automatic void add_item(logic kind, logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len,
                                     logic [POS_W-1:0] pos, logic [DELTA_W-1:0] dlt,
                                     logic [BTN_W-1:0] btn, logic press, int want_angle,
                                     logic acc, logic fired, logic alive);
        row_t r;
        r.is_write = 1'b0;
        r.reg_idx = '0;
        r.reg_value = '0;
        r.it = {kind, mac, len, pos, dlt, btn, press};
        r.typed = (want_angle >= 0);
        r.want = {ANGLE_W'(want_angle), acc, fired, alive};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        row_t r;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_value = value;
        r.it = '0;
        r.typed = 1'b0;
        r.want = '0;
        directed_rows.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
        mismatches++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
    endtask

    // Entered and left at a falling edge; valid stays high when the next item follows at once.
    task automatic send_item(item_t it, bit typed, result_t want);
        bit      taken;
        result_t res;
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= it.cmd;
        src_mac <= it.src_mac;
        packet_length <= it.packet_length;
        encoder_position <= it.encoder_position;
        encoder_delta <= it.encoder_delta;
        buttons <= it.buttons;
        encoder_pressed <= it.encoder_pressed;
        in_valid <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
            if (taken)
            begin
                res = advance_servo(it);
                pending_results.push_back(typed ? want : res);
                items_sent++;
                if (res.packet_accepted)
                    packets_taken++;
                if (res.timed_out)
                    timeouts_seen++;
                if (res.packet_accepted || (it.cmd == CMD_TICK && (res.link_alive || res.timed_out)))
                    live_items++;
            end
            @(negedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SENDER_FILTER: flt_mac = value[MAC_W-1:0];
            CFG_TIMEOUT_MS:    link_timeout = value[TIMEOUT_W-1:0];
            CFG_STEP_GAIN:     gain = value[GAIN_W-1:0];
            CFG_CENTER_ANGLE:  home_angle = value[ANGLE_W-1:0];
            CFG_MIN_ANGLE:     lower_limit = value[ANGLE_W-1:0];
            CFG_MAX_ANGLE:     upper_limit = value[ANGLE_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    remote_servo_position_controller_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .src_mac          (src_mac),
        .packet_length    (packet_length),
        .encoder_position (encoder_position),
        .encoder_delta    (encoder_delta),
        .buttons          (buttons),
        .encoder_pressed  (encoder_pressed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .angle            (angle),
        .packet_accepted  (packet_accepted),
        .timed_out        (timed_out),
        .link_alive       (link_alive),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none expected", angle, '0);
            else
            begin
                oldest = pending_results.pop_front();
                if (angle !== oldest.angle)
                    report_mismatch("angle", angle, oldest.angle);
                if (packet_accepted !== oldest.packet_accepted)
                    report_mismatch("packet_accepted", packet_accepted, oldest.packet_accepted);
                if (timed_out !== oldest.timed_out)
                    report_mismatch("timed_out", timed_out, oldest.timed_out);
                if (link_alive !== oldest.link_alive)
                    report_mismatch("link_alive", link_alive, oldest.link_alive);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit with %0d results outstanding",
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned burst, burst_cap, phase_start, room;
        idle_mode_t  mode;

        // Link down after reset: ticks and packets of the wrong length change nothing.
        add_item(CMD_TICK,   MAC_ONES, 8'd16,  32'd0,          16'h7FFF, 8'hFF, 1'b1,  90, 0, 0, 0);
        add_item(CMD_PACKET, '0,       8'd15,  32'd0,          16'h7FFF, 8'hFF, 1'b1,  90, 0, 0, 0);
        add_item(CMD_PACKET, '0,       8'd255, 32'd0,          16'h0,    8'h01, 1'b0,  90, 0, 0, 0);
        add_item(CMD_PACKET, '0,       8'd0,   32'd0,          16'h0,    8'h01, 1'b0,  90, 0, 0, 0);
        // The first accepted packet moves by its own delta: 90 plus 10 steps of 4.
        add_item(CMD_PACKET, MAC_ONES, 8'd16,  32'd1000,       16'd10,   8'h00, 1'b0, 130, 1, 0, 1);
        // After that the change in position counts and the delta is ignored.
        add_item(CMD_PACKET, '0,       8'd16,  32'd1000,       16'h8000, 8'h00, 1'b0, 130, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'd900,        16'h0,    8'h00, 1'b0,   0, 1, 0, 1);
        // Position differences wrap at 32 bits.
        add_item(CMD_PACKET, '0,       8'd16,  32'h8000_0000,  16'h0,    8'h00, 1'b0, 180, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h00, 1'b0, 176, 1, 0, 1);
        // The lowest preset button wins; bits 6 and 7 have no effect.
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h1E, 1'b0,  45, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h10, 1'b0, 180, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h08, 1'b0, 135, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h04, 1'b0,  90, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h01, 1'b0,   0, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'hC0, 1'b0,   0, 1, 0, 1);
        // The center button and the encoder press override the presets.
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h21, 1'b0,  90, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h7FFF_FFFF,  16'h0,    8'h01, 1'b1,  90, 1, 0, 1);
        add_item(CMD_PACKET, '0,       8'd16,  32'h8000_0001,  16'h0,    8'h00, 1'b0,  -1, 0, 0, 0);
        add_item(CMD_TICK,   '0,       8'd0,   32'd0,          16'h0,    8'h00, 1'b0,  -1, 0, 0, 0);
        // With a timeout of one, the second quiet tick re-centres and drops the link.
        add_write(CFG_TIMEOUT_MS, 48'd1);
        add_item(CMD_TICK,   '0,       8'd0,   32'd0,          16'h0,    8'h00, 1'b0,  90, 0, 1, 0);
        add_item(CMD_TICK,   '0,       8'd0,   32'd0,          16'h0,    8'h00, 1'b0,  90, 0, 0, 0);
        add_write(CFG_SENDER_FILTER, MAC_ONES);
        add_item(CMD_PACKET, '0,       8'd16,  32'h8000_0001,  16'h0,    8'h00, 1'b0,  90, 0, 0, 0);
        add_item(CMD_PACKET, MAC_ONES, 8'd16,  32'h8000_0001,  16'h0,    8'h00, 1'b0,  90, 1, 0, 1);
        // A lower limit above the upper one: the upper limit wins.
        add_write(CFG_MIN_ANGLE, 48'd150);
        add_write(CFG_MAX_ANGLE, 48'd100);
        add_item(CMD_PACKET, MAC_ONES, 8'd16,  32'h8000_0001,  16'h0,    8'h01, 1'b0, 100, 1, 0, 1);
        add_write(CFG_CENTER_ANGLE, 48'd180);
        add_item(CMD_PACKET, MAC_ONES, 8'd16,  32'h8000_0001,  16'h0,    8'h00, 1'b1, 100, 1, 0, 1);

        phase_cfg[0] = '{48'h0,           16'd20,    6'd4,  8'd90,  8'd0,   8'd180};
        phase_cfg[1] = '{48'h0,           16'd1,     6'd45, 8'd0,   8'd0,   8'd180};
        phase_cfg[2] = '{MAC_ONES,        16'd65535, 6'd0,  8'd180, 8'd30,  8'd150};
        phase_cfg[3] = '{48'h0,           16'd50,    6'd1,  8'd60,  8'd120, 8'd40};
        phase_cfg[4] = '{48'h0,           16'd7,     6'd9,  8'd180, 8'd180, 8'd180};
        phase_cfg[5] = '{48'h1,           16'd300,   6'd2,  8'd0,   8'd0,   8'd0};
        phase_cfg[1].sender_filter = MAC_W'({$urandom, $urandom});

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                wait_until_drained();
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            end
            else
                send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_drained();
            write_register(CFG_SENDER_FILTER, phase_cfg[p].sender_filter);
            write_register(CFG_TIMEOUT_MS, phase_cfg[p].timeout_ms);
            write_register(CFG_STEP_GAIN, phase_cfg[p].step_gain);
            write_register(CFG_CENTER_ANGLE, phase_cfg[p].center_angle);
            write_register(CFG_MIN_ANGLE, phase_cfg[p].min_angle);
            write_register(CFG_MAX_ANGLE, phase_cfg[p].max_angle);
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_SENDER:   {sender_gap_pct, receiver_stall_pct} = {HEAVY_PCT, 32'd0};
                IDLE_RECEIVER: {sender_gap_pct, receiver_stall_pct} = {32'd0, HEAVY_PCT};
                IDLE_BOTH:     {sender_gap_pct, receiver_stall_pct} = {LIGHT_PCT, LIGHT_PCT};
                default:       {sender_gap_pct, receiver_stall_pct} = '0;
            endcase
            burst_cap = (link_timeout > BURST_CAP - 3) ? BURST_CAP : link_timeout + 3;
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                // Runs of silent ticks, often just long enough to let the link time out.
                if ($urandom_range(99) < 8)
                begin
                    burst = $urandom_range(1) ? $urandom_range(1, burst_cap) : burst_cap;
                    room = ITEMS_PER_PHASE - (items_sent - phase_start);
                    if (burst > room)
                        burst = room;
                    repeat (burst) send_item(make_item(1'b1), 1'b0, '0);
                end
                else
                    send_item(make_item($urandom_range(99) < 30), 1'b0, '0);
            end
        end

        wait_until_drained();
        $display("ran %0d directed rows and %0d items in all over %0d register settings",
                 directed_rows.size(), items_sent, NUM_PHASES);
        $display("%0d live items, %0d packets accepted, %0d link timeouts, %0d mismatches",
                 live_items, packets_taken, timeouts_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
